### design/sst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes for the sorted set table
// Request and status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SST_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int POSITION_W   = 4;
    localparam int COUNT_W      = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic load;    // capture request and compare masks
        logic commit;  // update the table and the result register
    } sst_cmd_t;

endpackage
`default_nettype wire

### design/sst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_ctrl: request sequencer
// Accepts a request, then commits it once the result register is free.
// ----------------------------------------------------------------------------
module sst_ctrl
    import sst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output sst_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### design/sst_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_datapath: key cells, entry count and result register
// Each cell compares its key against the request key; the registered
// less/equal masks steer a one-step shift up (insert) or down (delete).
// ----------------------------------------------------------------------------
module sst_datapath
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sst_cmd_t                    cmd,
    input  wire logic        [OP_W-1:0]      operation,
    input  wire logic signed [KEY_W-1:0]     key,
    output logic             [STATUS_W-1:0]  status,
    output logic             [POSITION_W-1:0] position,
    output logic             [COUNT_W-1:0]   entry_count
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] cell_reg  [CAPACITY];
    logic signed [KEY_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    logic [OP_W-1:0]         op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CAPACITY-1:0]     less_reg;
    logic [CAPACITY-1:0]     eq_reg;
    logic [CAPACITY-1:0]     less_now;
    logic [CAPACITY-1:0]     eq_now;

    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [PW-1:0]           pos_reg;
    logic [PW-1:0]           pos_next;

    logic [CAPACITY-1:0]     edge_hot;
    logic [PW-1:0]           edge_pos;
    logic                    hit;
    logic                    full;
    logic                    do_insert;
    logic                    do_delete;

    // compare every held cell against the incoming key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            less_now[i] = (CW'(i) < count_reg) && (cell_reg[i] < key);
            eq_now[i]   = (CW'(i) < count_reg) && (cell_reg[i] == key);
        end
    end

    // first cell not less than the key marks the sorted position
    always_comb
    begin
        edge_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                edge_hot[i] = !less_reg[i];
            else
                edge_hot[i] = !less_reg[i] && less_reg[i-1];
            if (edge_hot[i])
                edge_pos = edge_pos | PW'(i);
        end
    end

    assign hit  = |eq_reg;
    assign full = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        status_next = ST_OK;
        pos_next    = '0;
        count_next  = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (hit)
                    status_next = ST_DUP;
                else
                begin
                    do_insert  = 1'b1;
                    pos_next   = edge_pos;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (!hit)
                    status_next = ST_MISSING;
                else
                begin
                    do_delete  = 1'b1;
                    pos_next   = edge_pos;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                if (!hit)
                    status_next = ST_MISSING;
                else
                    pos_next = edge_pos;
            end
        endcase
    end

    // per-cell next value: hold below the position, shift above it
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_insert && !less_reg[i])
            begin
                if (edge_hot[i])
                    cell_next[i] = key_reg;
                else if (i > 0)
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_delete && !less_reg[i] && (i < CAPACITY - 1))
            begin
                cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            less_reg <= less_now;
            eq_reg   <= eq_now;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cell_reg[i] <= cell_next[i];
            status_reg <= status_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    assign status      = status_reg;
    assign position    = POSITION_W'(pos_reg);
    assign entry_count = COUNT_W'(count_reg);

endmodule
`default_nettype wire

### design/sorted_set_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_table: ordered table of distinct signed keys
// A request is accepted in the idle state, where its key is compared against
// the key cells and the masks are registered; the update state then commits
// the cells and the result register. No new request is taken until the last
// one has committed; commit waits while a prior result is held.
// Reset clears the entry count and the control state; key cells are not
// cleared and are never compared above the entry count.
// ----------------------------------------------------------------------------
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic        [OP_W-1:0]       operation,
    input  wire logic signed [KEY_W-1:0]      key,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic             [STATUS_W-1:0]   status,
    output logic             [POSITION_W-1:0] position,
    output logic             [COUNT_W-1:0]    entry_count
);

    sst_cmd_t cmd;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .key         (key),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

endmodule
`default_nettype wire
